[design/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W          = 32;
  localparam int OCC_W            = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                      operation;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [OCC_W-1:0]          occupancy;
  } out_item_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                      shift_in;
    logic                      shift_out;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

[design/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value and trades with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic                      occupied,
  input  logic                      left_ge,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [VALUE_W-1:0] right_value,
  output logic                      ge,
  output logic signed [VALUE_W-1:0] value
);

  logic signed [VALUE_W-1:0] value_next;

  // An empty slot behaves as +infinity, so it always yields to a new value
  assign ge = occupied ? (value >= cmd.value) : 1'b1;

  // Pick the slot's next content
  always_comb begin
    value_next = value;
    if (cmd.shift_in) begin
      if (ge && left_ge) begin
        value_next = left_value;
      end else if (ge) begin
        value_next = cmd.value;
      end
    end else if (cmd.shift_out) begin
      value_next = right_value;
    end
  end

  // Hold the slot content
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[design/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// The result of each input transfer is registered in the output register.
// Throughput: one item per cycle unless the output stalls; all cells of the chain
// update in parallel, each comparing with the new value and taking from a neighbour.
// Reset: synchronous, clears the fill count and the output valid; the cells
// are not cleared, since only the first count slots are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Min-priority queue kept as an ascending chain of cells with a fill count.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  cell_cmd_t                 cmd;
  logic                      ge_chain [CAPACITY];
  logic signed [VALUE_W-1:0] val_chain [CAPACITY];
  logic [CW+OCC_W-1:0]       count_ext;
  out_item_t                 result;

  // Accept whenever the output register is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Broadcast the command to the chain
  assign cmd.shift_in  = accept && (in_data.operation == OP_INSERT) && !is_full;
  assign cmd.shift_out = accept && (in_data.operation == OP_REMOVE) && !is_empty;
  assign cmd.value     = in_data.value;

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_ge;
    logic signed [VALUE_W-1:0] l_val;
    logic signed [VALUE_W-1:0] r_val;
    if (i == 0) begin : g_head
      assign l_ge  = 1'b0;
      assign l_val = '0;
    end else begin : g_mid
      assign l_ge  = ge_chain[i-1];
      assign l_val = val_chain[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_val = '0;
    end else begin : g_body
      assign r_val = val_chain[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (CW'(i) < count),
      .left_ge    (l_ge),
      .left_value (l_val),
      .right_value(r_val),
      .ge         (ge_chain[i]),
      .value      (val_chain[i])
    );
  end

  // Advance the fill count
  always_comb begin
    count_next = count;
    if (cmd.shift_in) begin
      count_next = count + CW'(1);
    end else if (cmd.shift_out) begin
      count_next = count - CW'(1);
    end
  end

  // Form the result
  assign count_ext = {{OCC_W{1'b0}}, count_next};
  always_comb begin
    result.status        = STATUS_OK;
    result.removed_value = '0;
    result.occupancy     = count_ext[OCC_W-1:0];
    if (in_data.operation == OP_INSERT) begin
      if (is_full) begin
        result.status = STATUS_FULL;
      end
    end else if (is_empty) begin
      result.status = STATUS_EMPTY;
    end else begin
      result.removed_value = val_chain[0];
    end
  end

  // Hold count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

[tb/spq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches both channels of the sorted priority queue. Every input transfer
// goes through a behavioural copy of the queue to give the expected result.
// Every output transfer is compared, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
module spq_result_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  // Behavioural store, kept in ascending order
  logic signed [VALUE_W-1:0] held_values[$];
  // Results still owed by the queue, oldest first
  out_item_t                 owed_results[$];
  out_item_t                 want;
  int                        result_idx;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    result_idx  = 0;
  end

  // Apply one operation to the behavioural store and form its result
  function automatic out_item_t apply_queue_op(in_item_t item);
    out_item_t res;
    int        pos;
    res = '0;
    if (item.operation == OP_INSERT) begin
      if (held_values.size() >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        // new value goes ahead of every stored value that is not smaller
        pos = 0;
        while (pos < held_values.size() &&
               $signed(held_values[pos]) < $signed(item.value))
          pos++;
        held_values.insert(pos, item.value);
        res.status = STATUS_OK;
      end
    end else if (held_values.size() == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.removed_value = held_values.pop_front();
      res.status        = STATUS_OK;
    end
    res.occupancy = OCC_W'(held_values.size());
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, result_idx, msg);
  endtask

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    if (rst) begin
      held_values.delete();
      owed_results.delete();
      result_idx = 0;
    end else begin
      if (in_valid && in_ready)
        owed_results.push_back(apply_queue_op(in_data));
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("no result was due, got status %0d value %0d occ %0d",
                                    out_data.status, out_data.removed_value,
                                    out_data.occupancy));
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value got %0d, expected %0d",
                                      out_data.removed_value, want.removed_value));
          if (out_data.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                      out_data.occupancy, want.occupancy));
        end
        result_idx++;
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

[tb/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives inserts and removes into the sorted priority queue: a directed run
// over the value extremes, equal values, the empty and the full queue, then
// random bursts that push the fill level between empty and full under
// several sender and receiver idling patterns. The checker does the scoring.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_CAPACITY  = DEFAULT_CAPACITY;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int CYCLE_LIMIT     = 400000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  spq_result_checker #(
    .CAPACITY(QUEUE_CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

  // Offer one item, idling first at random, and hold it until the transfer
  task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v);
    in_item_t item;
    item.operation = op;
    item.value     = v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender off until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mix of extremes, small values that repeat, and full-range values
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed(32'($urandom_range(7))) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Extremes, equal values, remove from empty, fill to capacity, insert when full
  task automatic run_directed();
    logic signed [VALUE_W-1:0] fill_values[16];
    fill_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 0, 0, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sh7FFF_FFFE, 32'sh8000_0001, -1, 100, -100,
                    1, 32'sh7FFF_FFFF};
    send_item(OP_REMOVE, $signed($urandom));
    foreach (fill_values[i])
      send_item(OP_INSERT, fill_values[i]);
    send_item(OP_INSERT, 5);
    repeat (7) send_item(OP_REMOVE, $signed($urandom));
  endtask

  // Bursts leaning towards inserts or removes, so the fill level swings
  task automatic run_random(input int count);
    int   insert_pct;
    logic op;
    insert_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 24 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_item(op, random_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain_results();

    // no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);
    drain_results();
    // sender mostly idle
    send_idle_pct  = 79;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);
    drain_results();
    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_random(ITEMS_PER_PHASE);
    drain_results();
    // both sides idling
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(ITEMS_PER_PHASE);
    drain_results();
    // back to full rate
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // let any stray result show up
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
